/* hdl/binary_dilation_safe_count_top_defines.svh */
// assertion macros used by the checker file
`ifndef BINARY_DILATION_SAFE_COUNT_TOP_DEFINES_SVH
`define BINARY_DILATION_SAFE_COUNT_TOP_DEFINES_SVH

// check on every clock edge outside reset
`define BDSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also holds across reset
`define BDSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/bdsc_pkg.sv */
// shared constants, types and helpers of the safe cell counter
`timescale 1ns / 1ps

package bdsc_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;
    localparam int SIZE_W         = 8;
    localparam int COUNT_W        = 15;
    localparam int CFG_IDX_W      = 8;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 8'd0,
        CFG_GRID_HEIGHT = 8'd1
    } t_cfg_idx;

    // last valid index for a size register: zero acts as one, large values saturate
    function automatic int clamp_last(logic [SIZE_W-1:0] v, int max_size);
        int sz;
        sz = int'(v);
        if (sz == 0) begin
            return 0;
        end else if (sz > max_size) begin
            return max_size - 1;
        end
        return sz - 1;
    endfunction

endpackage

/* hdl/bdsc_ram.sv */
// generic simple dual port ram, one write and one registered read per cycle
`timescale 1ns / 1ps

module bdsc_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/binary_dilation_safe_count_top.sv */
// streaming 3x3 dilation of a mine grid with a count of safe cells
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------
//  input   | i_valid / o_stall           | i_mine
//  output  | o_valid / i_stall           | o_safe_count
//  config  | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one item per clock if not stalled; the count shows the cycle after a grid's last cell
// line buffer reads are registered and issued at the column of the next item
// synchronous reset clears position, windows, count and output; buffers are not cleared
// o_stall rises only at the final cell of a grid while an earlier count is still stalled
`timescale 1ns / 1ps

module binary_dilation_safe_count_top
    import bdsc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mine,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [COUNT_W-1:0]   o_safe_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CW-1:0]      r_col_last;
    logic [RW-1:0]      r_row_last;
    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_row, n_row;
    logic [1:0]         r_mid_win, n_mid_win;
    logic [1:0]         r_last_win, n_last_win;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_byp_hit;
    logic [1:0]         r_byp_data;

    logic       cfg_wr;
    logic       cfg_clear;
    logic       accept;
    logic       first_col, last_col, last_row, final_cell;
    logic [1:0] rd_data, buf_data, wr_data;
    logic       top, up, v_mid, v_last;
    logic [2:0] add;
    logic [COUNT_W-1:0] sum;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    // only a write to a known register restarts the grid
    assign cfg_clear   = cfg_wr && (i_cfg_index inside {CFG_GRID_WIDTH, CFG_GRID_HEIGHT});

    assign first_col  = (r_col == '0);
    assign last_col   = (r_col == r_col_last);
    assign last_row   = (r_row == r_row_last);
    assign final_cell = last_col && last_row;

    assign o_stall = final_cell && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // bit 1 is the row two above, bit 0 the row above
    bdsc_ram #(
        .DATA_W(2),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_wr_en  (accept),
        .i_wr_addr(r_col),
        .i_wr_data(wr_data),
        .i_rd_addr(n_col),
        .o_rd_data(rd_data)
    );

    // a one-column row writes and reads the same entry in the same cycle
    assign buf_data = r_byp_hit ? r_byp_data : rd_data;

    assign top    = (r_row > RW'(1)) ? buf_data[1] : 1'b0;
    assign up     = (r_row != '0) ? buf_data[0] : 1'b0;
    assign v_mid  = top | up | i_mine;
    assign v_last = up | i_mine;
    assign wr_data = {up, i_mine};

    always_comb begin
        add        = '0;
        n_mid_win  = r_mid_win;
        n_last_win = r_last_win;
        if (r_row != '0) begin
            if (!first_col && !(r_mid_win[0] | r_mid_win[1] | v_mid)) begin
                add = add + 3'd1;
            end
            if (last_col && !(r_mid_win[0] | v_mid)) begin
                add = add + 3'd1;
            end
            n_mid_win = last_col ? 2'b00 : {r_mid_win[0], v_mid};
        end
        if (last_row) begin
            if (!first_col && !(r_last_win[0] | r_last_win[1] | v_last)) begin
                add = add + 3'd1;
            end
            if (last_col && !(r_last_win[0] | v_last)) begin
                add = add + 3'd1;
            end
            n_last_win = last_col ? 2'b00 : {r_last_win[0], v_last};
        end
        if (last_col) begin
            n_mid_win  = 2'b00;
            n_last_win = 2'b00;
        end
    end

    assign sum = r_count + COUNT_W'(add);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_count = r_count;
        if (cfg_clear) begin
            n_col   = '0;
            n_row   = '0;
            n_count = '0;
        end else if (accept) begin
            n_col   = last_col ? '0 : r_col + CW'(1);
            n_count = final_cell ? '0 : sum;
            if (last_col) begin
                n_row = last_row ? '0 : r_row + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last  <= CW'(clamp_last(GRID_SIZE_RESET, MAX_WIDTH));
            r_row_last  <= RW'(clamp_last(GRID_SIZE_RESET, MAX_HEIGHT));
            r_col       <= '0;
            r_row       <= '0;
            r_mid_win   <= '0;
            r_last_win  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_byp_hit   <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_count   <= n_count;
            r_byp_hit <= accept && (n_col == r_col);
            if (cfg_clear) begin
                r_mid_win  <= '0;
                r_last_win <= '0;
            end else if (accept) begin
                r_mid_win  <= n_mid_win;
                r_last_win <= n_last_win;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH: begin
                        r_col_last <= CW'(clamp_last(i_cfg_data, MAX_WIDTH));
                    end
                    CFG_GRID_HEIGHT: begin
                        r_row_last <= RW'(clamp_last(i_cfg_data, MAX_HEIGHT));
                    end
                    default: begin
                    end
                endcase
            end
            if (accept && final_cell) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= wr_data;
        if (accept && final_cell) begin
            r_out_count <= sum;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_safe_count = r_out_count;

endmodule

/* hdl/bdsc_checker.sv */
// port level checks of the safe cell counter and their bind
`timescale 1ns / 1ps
`include "binary_dilation_safe_count_top_defines.svh"

module bdsc_checker
    import bdsc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [COUNT_W-1:0]   o_safe_count
);

    `BDSC_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_safe_count), "count moved")
    `BDSC_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid, "result valid after reset")
    `BDSC_ASSERT(a_rise_item, $rose(o_valid) |-> $past(i_valid && !o_stall), "count with no item")
    `BDSC_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "input stalled with free output")

endmodule

bind binary_dilation_safe_count_top bdsc_checker u_bdsc_checker (.*);
